### hdl/ook_remote_frame_transmitter_assert.svh
// Assertion macros for the OOK remote frame transmitter.
// Depends on nothing; included by the modules that check their own logic.
`ifndef OOK_REMOTE_FRAME_TRANSMITTER_ASSERT_SVH
`define OOK_REMOTE_FRAME_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OOK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ook transmitter check failed");

// Next-cycle implication, disabled during reset.
`define OOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ook transmitter check failed");

`endif

### hdl/ook_rft_pkg.sv
// Types and constants for the OOK remote frame transmitter.
// Used by ook_remote_frame_transmitter; depends on nothing.
package ook_rft_pkg;

  // Field widths.
  localparam int unsigned HouseW  = 26;
  localparam int unsigned UnitW   = 4;
  localparam int unsigned FrameW  = 32;
  localparam int unsigned ShortW  = 12;
  localparam int unsigned LongW   = 12;
  localparam int unsigned GapW    = 13;
  localparam int unsigned PauseW  = 20;
  localparam int unsigned RepeatW = 4;
  localparam int unsigned CountW  = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 20;

  // Register defaults after reset.
  localparam logic [ShortW-1:0]  ShortReset  = 12'd310;
  localparam logic [LongW-1:0]   LongReset   = 12'd1510;
  localparam logic [GapW-1:0]    GapReset    = 13'd3130;
  localparam logic [PauseW-1:0]  PauseReset  = 20'd10000;
  localparam logic [RepeatW-1:0] RepeatReset = 4'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgShort  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLong   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGap    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPause  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRepeat = 3'd4;

  // Input operation codes.
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Waveform phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_GAP   = 3'd2,
    PH_DATA  = 3'd3,
    PH_STOP  = 3'd4,
    PH_PAUSE = 3'd5
  } phase_t;

  // Input beat.
  typedef struct packed {
    logic              operation;
    logic [HouseW-1:0] house_code;
    logic [UnitW-1:0]  unit_code;
    logic              turn_on;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic rf_line;
    logic busy_res;
    logic start_refused;
    logic finished;
  } out_beat_t;

  // A length of zero counts as one tick.
  function automatic logic [CountW-1:0] at_least_one(input logic [CountW-1:0] v);
    at_least_one = (v == '0) ? CountW'(1) : v;
  endfunction

endpackage

### hdl/ook_remote_frame_transmitter.sv
// OOK remote frame transmitter, one beat per cycle while no stalled result waits;
// each result beat is registered in the cycle after its input beat is accepted.
// The next-state logic between the state and result registers is a single 20-bit
// increment and compare. Synchronous active-high reset sets the line low, the
// phase idle and the configuration registers to their defaults; no clearing pass
// is needed. Depends on ook_rft_pkg and ook_remote_frame_transmitter_assert.svh.
`include "ook_remote_frame_transmitter_assert.svh"

module ook_remote_frame_transmitter
  import ook_rft_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_beat_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_beat_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_data
);

  // Configuration registers.
  logic [ShortW-1:0]  short_ticks;
  logic [LongW-1:0]   long_ticks;
  logic [GapW-1:0]    start_gap_ticks;
  logic [PauseW-1:0]  pause_ticks;
  logic [RepeatW-1:0] repeat_count;

  // Waveform state.
  logic [FrameW-1:0]  frame_bits, frame_bits_next;
  phase_t             phase, phase_next;
  logic [4:0]         bit_index, bit_index_next;
  logic [1:0]         sub_pulse, sub_pulse_next;
  logic [CountW-1:0]  tick_count, tick_count_next;
  logic [RepeatW-1:0] repeats_left, repeats_left_next;
  logic               line_level, line_level_next;

  logic               in_accept;
  logic               busy;
  logic               cur_bit;
  logic [CountW-1:0]  seg_len;
  logic [CountW-1:0]  tick_inc;
  logic [RepeatW-1:0] rep_dec;
  out_beat_t          result;

  // The input is held only while a result beat waits and is stalled.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign busy      = (phase != PH_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks     <= ShortReset;
      long_ticks      <= LongReset;
      start_gap_ticks <= GapReset;
      pause_ticks     <= PauseReset;
      repeat_count    <= RepeatReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgShort:  short_ticks     <= cfg_data[ShortW-1:0];
        CfgLong:   long_ticks      <= cfg_data[LongW-1:0];
        CfgGap:    start_gap_ticks <= cfg_data[GapW-1:0];
        CfgPause:  pause_ticks     <= cfg_data[PauseW-1:0];
        CfgRepeat: repeat_count    <= cfg_data[RepeatW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Length of the segment now being sent.
  assign cur_bit = frame_bits[5'(FrameW - 1) - bit_index];

  always_comb begin
    unique case (phase)
      PH_START, PH_STOP: seg_len = at_least_one(CountW'(short_ticks));
      PH_GAP:            seg_len = at_least_one(CountW'(start_gap_ticks));
      PH_PAUSE:          seg_len = CountW'(pause_ticks);
      PH_DATA: begin
        if ((sub_pulse == 2'd1 && cur_bit) || (sub_pulse == 2'd3 && !cur_bit)) begin
          seg_len = at_least_one(CountW'(long_ticks));
        end else begin
          seg_len = at_least_one(CountW'(short_ticks));
        end
      end
      default:           seg_len = CountW'(1);
    endcase
  end

  assign tick_inc = tick_count + CountW'(1);
  assign rep_dec  = repeats_left - RepeatW'(1);

  // Next-state logic for one accepted beat.
  always_comb begin
    frame_bits_next   = frame_bits;
    phase_next        = phase;
    bit_index_next    = bit_index;
    sub_pulse_next    = sub_pulse;
    tick_count_next   = tick_count;
    repeats_left_next = repeats_left;
    line_level_next   = line_level;
    if (in_accept) begin
      priority if (in_data.operation == OpStart) begin
        if (!busy) begin
          frame_bits_next   = {in_data.house_code, 1'b0, in_data.turn_on, in_data.unit_code};
          repeats_left_next = (repeat_count == '0) ? RepeatW'(1) : repeat_count;
          phase_next        = PH_START;
          bit_index_next    = '0;
          sub_pulse_next    = '0;
          tick_count_next   = '0;
          line_level_next   = 1'b1;
        end
      end else if (!busy) begin
        phase_next      = PH_IDLE;
        line_level_next = 1'b0;
      end else if (tick_inc >= seg_len) begin
        tick_count_next = '0;
        unique case (phase)
          PH_START: begin
            phase_next      = PH_GAP;
            line_level_next = 1'b0;
          end
          PH_GAP: begin
            phase_next      = PH_DATA;
            bit_index_next  = '0;
            sub_pulse_next  = '0;
            line_level_next = 1'b1;
          end
          PH_DATA: begin
            priority if (sub_pulse != 2'd3) begin
              sub_pulse_next  = sub_pulse + 2'd1;
              line_level_next = ~sub_pulse_next[0];
            end else if (bit_index != 5'd31) begin
              bit_index_next  = bit_index + 5'd1;
              sub_pulse_next  = '0;
              line_level_next = 1'b1;
            end else begin
              phase_next      = PH_STOP;
              sub_pulse_next  = '0;
              line_level_next = 1'b1;
            end
          end
          default: begin
            // Stop pulse with a pause goes to the pause; otherwise the frame ends.
            line_level_next = 1'b0;
            if (phase == PH_STOP && pause_ticks != '0) begin
              phase_next = PH_PAUSE;
            end else begin
              repeats_left_next = rep_dec;
              if (rep_dec == '0) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next      = PH_START;
                bit_index_next  = '0;
                sub_pulse_next  = '0;
                line_level_next = 1'b1;
              end
            end
          end
        endcase
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  // Result fields for the beat being accepted.
  always_comb begin
    result.rf_line       = line_level_next;
    result.busy_res      = (phase_next != PH_IDLE);
    result.start_refused = in_data.operation == OpStart && busy;
    result.finished      = in_data.operation == OpTick && busy && phase_next == PH_IDLE;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits   <= '0;
      phase        <= PH_IDLE;
      bit_index    <= '0;
      sub_pulse    <= '0;
      tick_count   <= '0;
      repeats_left <= '0;
      line_level   <= 1'b0;
    end else begin
      frame_bits   <= frame_bits_next;
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      sub_pulse    <= sub_pulse_next;
      tick_count   <= tick_count_next;
      repeats_left <= repeats_left_next;
      line_level   <= line_level_next;
    end
  end

  // Result register: loads on every accepted beat, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

  // Checks on the waveform state and the result register.
  `OOK_ASSERT_NOW(a_idle_line_low, clk, rst, phase == PH_IDLE, !line_level)
  `OOK_ASSERT_NOW(a_sub_only_in_data, clk, rst, phase != PH_DATA, sub_pulse == 2'd0)
  `OOK_ASSERT_NOW(a_finish_goes_idle, clk, rst, out_valid && out_data.finished,
                  !out_data.busy_res && !out_data.rf_line)
  `OOK_ASSERT_NOW(a_refused_stays_busy, clk, rst, out_valid && out_data.start_refused,
                  out_data.busy_res)
  `OOK_ASSERT_NEXT(a_start_loads, clk, rst,
                   in_accept && in_data.operation == OpStart && !busy,
                   phase == PH_START && line_level && repeats_left != '0)

endmodule

### dv/ook_remote_frame_transmitter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the OOK remote frame transmitter: a scripted opening,
// then random command/tick streams under several pacing patterns, scored per beat.
// Depends on ook_rft_pkg and the ook_remote_frame_transmitter RTL.

module ook_remote_frame_transmitter_tb;
  import ook_rft_pkg::*;

  typedef enum logic [1:0] {PACE_STEADY, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;
  typedef enum logic [1:0] {ROW_BEAT, ROW_REGS_ZERO, ROW_REGS_MAX} row_kind_t;

  // One scripted step; want is {rf_line, busy_res, start_refused, finished}.
  typedef struct packed {
    row_kind_t kind;
    in_beat_t  beat;
    logic      pinned;
    out_beat_t want;
  } script_row_t;

  typedef struct packed {
    logic      pinned;
    out_beat_t want;
  } pin_t;

  localparam logic [HouseW-1:0] HouseOnes = '1;
  localparam int ScriptLen = 20;
  localparam script_row_t Script [ScriptLen] = '{
    // Default lengths after reset.
    '{ROW_BEAT, '{OpTick,  HouseOnes,     4'hF, 1'b1}, 1'b1, 4'b0000},
    '{ROW_BEAT, '{OpStart, 26'd0,         4'h0, 1'b0}, 1'b1, 4'b1100},
    '{ROW_BEAT, '{OpStart, HouseOnes,     4'hF, 1'b1}, 1'b1, 4'b1110},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b1, 4'b1100},
    '{ROW_BEAT, '{OpTick,  HouseOnes,     4'hF, 1'b1}, 1'b1, 4'b1100},
    // Zero lengths shrink the start pulse below the ticks already counted.
    '{ROW_REGS_ZERO, '0, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b1, 4'b0100},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b1, 4'b1100},
    '{ROW_BEAT, '{OpTick,  26'h2AAAAAA,   4'hA, 1'b0}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'h1555555,   4'h5, 1'b1}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpStart, 26'h1555555,   4'h5, 1'b0}, 1'b0, 4'b0000},
    // Largest lengths while the frame is in flight.
    '{ROW_REGS_MAX, '0, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  HouseOnes,     4'hF, 1'b1}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpStart, HouseOnes,     4'hF, 1'b1}, 1'b0, 4'b0000},
    '{ROW_BEAT, '{OpTick,  26'd0,         4'h0, 1'b0}, 1'b0, 4'b0000}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_beat_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDatW-1:0]  cfg_data = '0;

  pace_t       pace = PACE_STEADY;
  bit          squeeze_pending = 1'b0;
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  pin_t        pins_q [$];
  out_beat_t   forecast_q [$];

  // Predicted transmitter registers and waveform state.
  logic [ShortW-1:0]  reg_short;
  logic [LongW-1:0]   reg_long;
  logic [GapW-1:0]    reg_gap;
  logic [PauseW-1:0]  reg_pause;
  logic [RepeatW-1:0] reg_repeat;
  logic [FrameW-1:0]  tx_frame;
  phase_t             tx_phase;
  logic [4:0]         tx_bit;
  logic [1:0]         tx_sub;
  logic [CountW-1:0]  tx_count;
  logic [RepeatW-1:0] tx_repeats;
  logic               tx_level;

  ook_remote_frame_transmitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Waveform predictor.
  function automatic void clear_keying();
    reg_short  = ShortReset;
    reg_long   = LongReset;
    reg_gap    = GapReset;
    reg_pause  = PauseReset;
    reg_repeat = RepeatReset;
    tx_frame   = '0;
    tx_phase   = PH_IDLE;
    tx_bit     = '0;
    tx_sub     = '0;
    tx_count   = '0;
    tx_repeats = '0;
    tx_level   = 1'b0;
  endfunction

  function automatic logic [CountW-1:0] floor_one(input logic [CountW-1:0] v);
    return (v == '0) ? CountW'(1) : v;
  endfunction

  // Length of the segment now on the air; a data bit's long gap sits in
  // the first low slot for a one and the second for a zero.
  function automatic logic [CountW-1:0] segment_ticks();
    logic cur;
    cur = tx_frame[5'd31 - tx_bit];
    case (tx_phase)
      PH_START, PH_STOP: return floor_one(CountW'(reg_short));
      PH_GAP:            return floor_one(CountW'(reg_gap));
      PH_PAUSE:          return reg_pause;
      PH_DATA: begin
        if ((tx_sub == 2'd1 && cur) || (tx_sub == 2'd3 && !cur))
          return floor_one(CountW'(reg_long));
        return floor_one(CountW'(reg_short));
      end
      default:           return CountW'(1);
    endcase
  endfunction

  function automatic void open_frame();
    tx_phase = PH_START;
    tx_bit   = '0;
    tx_sub   = '0;
    tx_count = '0;
    tx_level = 1'b1;
  endfunction

  // Returns 1 when the last repeat is done.
  function automatic logic close_frame();
    tx_repeats = tx_repeats - RepeatW'(1);
    if (tx_repeats == '0) begin
      tx_phase = PH_IDLE;
      tx_level = 1'b0;
      return 1'b1;
    end
    open_frame();
    return 1'b0;
  endfunction

  function automatic out_beat_t advance_keying(input in_beat_t b);
    out_beat_t r;
    logic      busy;
    r = '0;
    busy = (tx_phase != PH_IDLE);
    if (b.operation == OpStart) begin
      if (busy) begin
        r.start_refused = 1'b1;
      end else begin
        tx_frame   = {b.house_code, 1'b0, b.turn_on, b.unit_code};
        tx_repeats = (reg_repeat == '0) ? RepeatW'(1) : reg_repeat;
        open_frame();
      end
    end else if (!busy) begin
      tx_level = 1'b0;
    end else begin
      tx_count = tx_count + CountW'(1);
      if (tx_count >= segment_ticks()) begin
        tx_count = '0;
        case (tx_phase)
          PH_START: begin
            tx_phase = PH_GAP;
            tx_level = 1'b0;
          end
          PH_GAP: begin
            tx_phase = PH_DATA;
            tx_bit   = '0;
            tx_sub   = '0;
            tx_level = 1'b1;
          end
          PH_DATA: begin
            if (tx_sub != 2'd3) begin
              tx_sub   = tx_sub + 2'd1;
              tx_level = ~tx_sub[0];
            end else if (tx_bit != 5'd31) begin
              tx_bit   = tx_bit + 5'd1;
              tx_sub   = '0;
              tx_level = 1'b1;
            end else begin
              tx_phase = PH_STOP;
              tx_sub   = '0;
              tx_level = 1'b1;
            end
          end
          PH_STOP: begin
            tx_level = 1'b0;
            if (reg_pause != '0) tx_phase = PH_PAUSE;
            else r.finished = close_frame();
          end
          default: begin
            r.finished = close_frame();
          end
        endcase
      end
    end
    r.rf_line  = tx_level;
    r.busy_res = (tx_phase != PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("result beat %0d: %s got %b expected %b", beats_seen, what, got, want);
    mismatches++;
  endtask

  // Scoreboard: register writes, accepted input beats and result beats.
  always @(posedge clk) begin : scoreboard
    pin_t      pin;
    out_beat_t guess;
    out_beat_t got;
    out_beat_t want;
    if (rst) begin
      clear_keying();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgShort:  reg_short  = cfg_data[ShortW-1:0];
          CfgLong:   reg_long   = cfg_data[LongW-1:0];
          CfgGap:    reg_gap    = cfg_data[GapW-1:0];
          CfgPause:  reg_pause  = cfg_data[PauseW-1:0];
          CfgRepeat: reg_repeat = cfg_data[RepeatW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        pin = pins_q.pop_front();
        guess = advance_keying(in_data);
        forecast_q.push_back(pin.pinned ? pin.want : guess);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (forecast_q.size() == 0) begin
          report_mismatch("beat with nothing expected", 1'b1, 1'b0);
        end else begin
          want = forecast_q.pop_front();
          if (got.rf_line !== want.rf_line)
            report_mismatch("rf_line", got.rf_line, want.rf_line);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.start_refused !== want.start_refused)
            report_mismatch("start_refused", got.start_refused, want.start_refused);
          if (got.finished !== want.finished)
            report_mismatch("finished", got.finished, want.finished);
        end
        beats_seen++;
      end
    end
  end

  function automatic bit sender_waits();
    case (pace)
      PACE_SENDER: return $urandom_range(99) < 59;
      PACE_BOTH:   return $urandom_range(99) < 23;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace)
      PACE_RECEIVER: return $urandom_range(99) < 59;
      PACE_BOTH:     return $urandom_range(99) < 23;
      default:       return 1'b0;
    endcase
  endfunction

  // Receiver side; a squeeze holds the output off long enough to back up the input.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        out_stall <= receiver_stalls();
      end
    end
  end

  // Offer one beat and return at the edge that takes it.
  task automatic send_beat(input in_beat_t b, input logic pinned, input out_beat_t want);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pins_q.push_back('{pinned, want});
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every result beat has been scored.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pins_q.size() != 0 || forecast_q.size() != 0);
  endtask

  task automatic program_regs(input int unsigned s, l, g, p, n);
    int unsigned        vals [5];
    logic [CfgIdxW-1:0] idx [5];
    vals = '{s, l, g, p, n};
    idx  = '{CfgShort, CfgLong, CfgGap, CfgPause, CfgRepeat};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CfgDatW'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Short segments so that whole frames finish within a phase.
  task automatic small_regs();
    program_regs($urandom_range(2), $urandom_range(3), $urandom_range(3),
                 $urandom_range(3), $urandom_range(2));
  endtask

  // Mostly commands followed by ticks; a few refused starts ride on busy frames.
  function automatic in_beat_t draw_beat();
    in_beat_t    b;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0:       b.house_code = '0;
      1:       b.house_code = '1;
      default: b.house_code = r[HouseW-1:0];
    endcase
    b.unit_code = r[29:26];
    b.turn_on   = r[30];
    if (tx_phase == PH_IDLE) b.operation = ($urandom_range(3) != 0) ? OpStart : OpTick;
    else b.operation = ($urandom_range(39) == 0) ? OpStart : OpTick;
    return b;
  endfunction

  initial begin : stimulus
    int burst;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Scripted opening.
    for (int i = 0; i < ScriptLen; i++) begin
      case (Script[i].kind)
        ROW_REGS_ZERO: begin
          settle();
          program_regs(0, 0, 0, 0, 0);
        end
        ROW_REGS_MAX: begin
          settle();
          program_regs((1 << ShortW) - 1, (1 << LongW) - 1, (1 << GapW) - 1,
                       (1 << PauseW) - 1, (1 << RepeatW) - 1);
        end
        default: send_beat(Script[i].beat, Script[i].pinned, Script[i].want);
      endcase
    end

    // Random phases, each with its own lengths and pacing.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          small_regs();
          pace = PACE_STEADY;
          burst = 300;
        end
        1: begin
          program_regs(1, 1, 1, 0, 1);
          pace = PACE_SENDER;
          burst = 250;
        end
        2: begin
          program_regs(0, 0, 0, 0, 0);
          pace = PACE_RECEIVER;
          burst = 300;
        end
        3: begin
          program_regs((1 << ShortW) - 1, (1 << LongW) - 1, (1 << GapW) - 1,
                       (1 << PauseW) - 1, (1 << RepeatW) - 1);
          pace = PACE_BOTH;
          burst = 100;
        end
        4: begin
          small_regs();
          pace = PACE_STEADY;
          squeeze_pending = 1'b1;
          burst = 250;
        end
        default: begin
          small_regs();
          pace = PACE_BOTH;
          burst = 300;
        end
      endcase
      repeat (burst) send_beat(draw_beat(), 1'b0, '0);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ook_remote_frame_transmitter regression: pass");
    end else begin
      $display("ook_remote_frame_transmitter regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("ook_remote_frame_transmitter regression: fail");
    $finish;
  end

endmodule
